// File: rtl/bupa_pkg.sv
// Shared types and constants for the bitmap unit pool allocator.
// Used by every module of the block but bupa_ram; no dependencies.
package bupa_pkg;

  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 17;
  localparam int REQ_W     = 32;
  localparam int IDX_OUT_W = 10;
  localparam int MAP_W     = 64;

  localparam logic [2:0] ST_ALLOC     = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_FREE_OUT  = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [7:0] REG_POOL_BASE = 8'd0;
  localparam logic [7:0] REG_UNIT_SIZE = 8'd1;

  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic                kind;
    logic [REQ_W-1:0]    request_size;
    logic [ADDR_W-1:0]   release_address;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_W-1:0]    grant_address;
    logic [IDX_OUT_W-1:0] unit_index;
  } rsp_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [2:0]        status;
    logic [ADDR_W-1:0] offset;
  } cmd_t;

endpackage

// File: rtl/bupa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bupa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bupa_front.sv
// Front end: classify a request into a pass-through report or a command.
// Depends on bupa_pkg.
module bupa_front import bupa_pkg::*; #(
  parameter int UNIT_COUNT = 1024
) (
  input  req_t               req,
  input  logic [ADDR_W-1:0]  pool_base,
  input  logic [SIZE_W-1:0]  unit_size,
  output cmd_t               cmd
);
  localparam int SPAN_W = SIZE_W + 17;

  logic [SPAN_W-1:0] span;
  logic [ADDR_W:0]   diff;
  logic              outside;

  always_comb begin
    span = SPAN_W'(unit_size) * SPAN_W'(UNIT_COUNT);
    diff = {1'b0, req.release_address} - {1'b0, pool_base};
    // borrow means address is below the base
    outside = (unit_size == '0) || diff[ADDR_W] ||
              (diff[ADDR_W-1:0] >= ADDR_W'(span));
    cmd.offset = diff[ADDR_W-1:0];
    cmd.status = ST_ALLOC;
    cmd.op     = OP_PASS;
    if (req.kind == KIND_ALLOC) begin
      if (req.request_size > REQ_W'(unit_size)) begin
        cmd.status = ST_TOO_LARGE;
      end else begin
        cmd.op = OP_ALLOC;
      end
    end else begin
      if (outside) begin
        cmd.status = ST_FREE_OUT;
      end else begin
        cmd.op = OP_FREE;
      end
    end
  end
endmodule

// File: rtl/bupa_queue.sv
// Two-entry command queue between front end and back end.
// Depends on bupa_pkg.
module bupa_queue import bupa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);
  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/bupa_back.sv
// Back end: map clearing, lowest-free scan, address multiply, restoring
// divide for frees, and the result register. Depends on bupa_pkg, bupa_ram.
module bupa_back import bupa_pkg::*; #(
  parameter int UNIT_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ADDR_W-1:0]  pool_base,
  input  logic [SIZE_W-1:0]  unit_size,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp
);
  localparam int WORDS  = (UNIT_COUNT + MAP_W - 1) / MAP_W;
  localparam int WAW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int IDXW   = $clog2(UNIT_COUNT);
  localparam int QW     = IDXW > (6 + WAW) ? IDXW : (6 + WAW);
  localparam int CW     = $clog2(QW);
  localparam int OFF_W  = SIZE_W + QW;
  localparam int AIDX_W = WAW + 6;
  localparam int PROD_W = SIZE_W + AIDX_W;
  localparam int LAST_N = UNIT_COUNT - (WORDS - 1) * MAP_W;
  localparam logic [MAP_W-1:0] LAST_MASK =
    (LAST_N == MAP_W) ? {MAP_W{1'b1}} : ((MAP_W'(1) << LAST_N) - MAP_W'(1));

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_SCAN_ADDR = 9'b000000100,
    S_SCAN_CHK  = 9'b000001000,
    S_MUL       = 9'b000010000,
    S_ADD       = 9'b000100000,
    S_DIV       = 9'b001000000,
    S_FREE_RD   = 9'b010000000,
    S_FREE_WR   = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [WAW-1:0]      ptr;
  logic [AIDX_W-1:0]   aidx;
  logic [PROD_W-1:0]   prod;
  logic [OFF_W-1:0]    rem;
  logic [QW-1:0]       quot;
  logic [CW-1:0]       cnt;

  logic                we;
  logic [WAW-1:0]      waddr;
  logic [MAP_W-1:0]    wdata;
  logic [WAW-1:0]      raddr;
  logic [MAP_W-1:0]    rdata;
  logic [MAP_W-1:0]    free_bits;
  logic [5:0]          low_bit;
  logic                last_word;
  logic [OFF_W-1:0]    dsh;
  logic                take;

  bupa_ram #(.WIDTH(MAP_W), .DEPTH(WORDS)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign clearing  = (state == S_CLEAR);
  assign last_word = (ptr == WAW'(WORDS - 1));
  assign raddr     = (state == S_FREE_RD) ? quot[6 +: WAW] : ptr;
  assign dsh       = OFF_W'(unit_size) << cnt;
  assign take      = rsp_valid && !rsp_stall;

  always_comb begin
    free_bits = ~rdata & (last_word ? LAST_MASK : {MAP_W{1'b1}});
    low_bit = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        low_bit = 6'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty && !rsp_valid) begin
          q_pop = 1'b1;
          case (q_data.op)
            OP_ALLOC: state_next = S_SCAN_ADDR;
            OP_FREE:  state_next = S_DIV;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN_ADDR: state_next = S_MUL;
      S_SCAN_CHK: begin
        if (free_bits != '0) begin
          we    = 1'b1;
          wdata = rdata | (MAP_W'(1) << low_bit);
          state_next = S_MUL;
        end else if (last_word) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_ADDR;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_IDLE;
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_FREE_RD;
        end
      end
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: begin
        we    = 1'b1;
        waddr = quot[6 +: WAW];
        wdata = rdata & ~(MAP_W'(1) << quot[5:0]);
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // the map word is read in S_SCAN_ADDR and checked in the cycle after, in S_SCAN_CHK
    if (state == S_SCAN_ADDR) begin
      state_next = S_SCAN_CHK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          ptr <= last_word ? '0 : ptr + WAW'(1);
        end
        S_IDLE: begin
          ptr  <= '0;
          cnt  <= CW'(QW - 1);
          quot <= '0;
          rem  <= OFF_W'(q_data.offset);
          if (q_pop && q_data.op == OP_PASS) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: q_data.status, grant_address: '0, unit_index: '0};
          end
        end
        S_SCAN_CHK: begin
          if (free_bits != '0) begin
            aidx <= {ptr, low_bit};
          end else if (last_word) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: ST_FULL, grant_address: '0, unit_index: '0};
          end else begin
            ptr <= ptr + WAW'(1);
          end
        end
        S_MUL: begin
          prod <= PROD_W'(unit_size) * PROD_W'(aidx);
        end
        S_ADD: begin
          rsp_valid <= 1'b1;
          rsp <= '{status: ST_ALLOC,
                   grant_address: pool_base + ADDR_W'(prod),
                   unit_index: IDX_OUT_W'(aidx)};
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem       <= rem - dsh;
            quot[cnt] <= 1'b1;
          end
          cnt <= cnt - CW'(1);
        end
        S_FREE_WR: begin
          rsp_valid <= 1'b1;
          rsp <= '{status: ST_FREED, grant_address: '0,
                   unit_index: IDX_OUT_W'(quot)};
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// File: rtl/bitmap_unit_pool_allocator_core.sv
// Bitmap unit pool allocator: one result per request, in request order.
// Allocate: each map word is read (S_SCAN_ADDR) and checked (S_SCAN_CHK) in turn,
// then the address is multiplied (S_MUL) and added (S_ADD). Free: a one-bit-a-cycle
// divide, then a read and a write of the map word. One request is worked on at a time.
// Pass-through reports go straight to the result register. After reset the map is
// cleared one word a cycle, with req_stall high; registers reset to pool_base 0, unit_size 64.
module bitmap_unit_pool_allocator_core import bupa_pkg::*; #(
  parameter int UNIT_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] unit_size;
  cmd_t              cmd;
  cmd_t              q_data;
  logic              q_full, q_empty, q_pop, clearing, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      unit_size <= SIZE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_BASE: pool_base <= cfg_data;
        REG_UNIT_SIZE: unit_size <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign req_stall = q_full || clearing;
  assign push      = req_valid && !req_stall;

  bupa_front #(.UNIT_COUNT(UNIT_COUNT)) u_front (
    .req(req), .pool_base(pool_base), .unit_size(unit_size), .cmd(cmd)
  );

  bupa_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(cmd), .pop(q_pop),
    .pop_data(q_data), .full(q_full), .empty(q_empty)
  );

  bupa_back #(.UNIT_COUNT(UNIT_COUNT)) u_back (
    .clk(clk), .rst(rst), .pool_base(pool_base), .unit_size(unit_size),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop), .clearing(clearing),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );
endmodule

// File: rtl/bupa_checker.sv
// Port-level checks for the allocator top level, bound to it below.
// Depends on bupa_pkg.
module bupa_checker import bupa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_FREE_OUT)
    else $error("bad status code");

  a_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_ALLOC |-> rsp.grant_address == '0)
    else $error("address on non-grant result");

  a_no_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_TOO_LARGE || rsp.status == ST_FULL ||
    rsp.status == ST_FREE_OUT) |-> rsp.unit_index == '0)
    else $error("index on report result");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request taken during map clear");
endmodule

bind bitmap_unit_pool_allocator_core bupa_checker u_chk (.*);

// File: tb/tb_bitmap_unit_pool_allocator_core.sv
// Testbench for bitmap_unit_pool_allocator_core: directed and random allocate and
// free words with a local occupancy-map predictor. Depends on bupa_pkg and the core.
`timescale 1ns / 100ps

module tb_bitmap_unit_pool_allocator_core;
  import bupa_pkg::*;

  localparam int UNITS      = 1024;
  localparam int MAP_WORDS  = UNITS / MAP_W;
  localparam int MAX_CYCLES = 1000000;
  localparam int SETTLE     = 2 * MAP_WORDS + 12;
  localparam logic [7:0] REG_SPARE = 8'd2;
  localparam logic [7:0] REG_TOP   = 8'hFF;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [7:0]        cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall;
  rsp_t              rsp;

  // predictor state
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] usize_q;
  logic [MAP_W-1:0]  occ_map [MAP_WORDS];
  rsp_t              pending_rsp [$];
  logic [ADDR_W-1:0] granted [$];
  bit                failed;
  bit                quiet;
  int                cycles;

  bitmap_unit_pool_allocator_core #(.UNIT_COUNT(UNITS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic rsp_t pool_outcome(req_t r);
    rsp_t o;
    logic [63:0] span;
    logic [63:0] off;
    logic [63:0] idx;
    o = '0;
    if (r.kind == KIND_ALLOC) begin
      o.status = ST_FULL;
      if (64'(r.request_size) > 64'(usize_q)) begin
        o.status = ST_TOO_LARGE;
      end else begin
        for (int i = 0; i < UNITS; i++) begin
          if (!occ_map[i / MAP_W][i % MAP_W]) begin
            occ_map[i / MAP_W][i % MAP_W] = 1'b1;
            o.status = ST_ALLOC;
            o.grant_address = ADDR_W'(64'(base_q) + 64'(usize_q) * 64'(i));
            o.unit_index = IDX_OUT_W'(i);
            break;
          end
        end
      end
    end else begin
      span = 64'(usize_q) * 64'(UNITS);
      off  = 64'(r.release_address) - 64'(base_q);
      if (usize_q == 0 || r.release_address < base_q || off >= span) begin
        o.status = ST_FREE_OUT;
      end else begin
        idx = off / 64'(usize_q);
        occ_map[idx / MAP_W][idx % MAP_W] = 1'b0;
        o.status = ST_FREED;
        o.unit_index = IDX_OUT_W'(idx);
      end
    end
    return o;
  endfunction

  // checker and receiver stall
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < 18);
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, rsp);
          failed = 1'b1;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            failed = 1'b1;
          end
          if (rsp.grant_address !== want.grant_address) begin
            $display("%0t: grant_address expected %h actual %h", $time,
                     want.grant_address, rsp.grant_address);
            failed = 1'b1;
          end
          if (rsp.unit_index !== want.unit_index) begin
            $display("%0t: unit_index expected %0d actual %0d", $time,
                     want.unit_index, rsp.unit_index);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(req_t r);
    rsp_t o;
    if (!quiet && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 50) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    o = pool_outcome(r);
    pending_rsp.push_back(o);
    if (o.status == ST_ALLOC) granted.push_back(o.grant_address);
  endtask

  task automatic send_alloc(logic [REQ_W-1:0] size);
    req_t r;
    r = '0;
    r.kind = KIND_ALLOC;
    r.request_size = size;
    r.release_address = ADDR_W'({$urandom, $urandom});
    send_word(r);
  endtask

  task automatic send_free(logic [ADDR_W-1:0] addr);
    req_t r;
    r = '0;
    r.kind = KIND_FREE;
    r.release_address = addr;
    r.request_size = $urandom;
    send_word(r);
  endtask

  // drop valid and wait for every word, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POOL_BASE;
    cfg_data  <= base;
    @(posedge clk);
    base_q = base;
    cfg_index <= REG_UNIT_SIZE;
    cfg_data  <= size_word;
    @(posedge clk);
    usize_q = SIZE_W'(size_word);
    cfg_index <= ($urandom_range(1)) ? REG_SPARE : REG_TOP;
    cfg_data  <= ADDR_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    granted.delete();
  endtask

  task automatic test_basic();
    send_alloc(0);
    send_alloc(64);
    send_alloc(65);
    send_alloc(32'hFFFF_FFFF);
    send_free(0);
    send_free(0);
    send_free(48'd69);
    send_free(48'd65536);
    send_free(48'hFFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_base_offset();
    configure(48'h100, 48'd16);
    send_alloc(16);
    send_free(48'h50);
    send_free(48'h100 + 48'd16 * 48'd1023 + 48'd15);
    send_free(48'h100 + 48'd16 * 48'd1024);
    drain();
  endtask

  task automatic test_zero_unit();
    configure(48'h1234, 48'd0);
    send_alloc(0);
    send_alloc(1);
    send_free(48'h1234);
    drain();
  endtask

  task automatic test_wrap_and_big_units();
    configure(48'hFFFF_FFFF_FF00, 48'd65536);
    repeat (3) send_alloc(65536);
    send_alloc(65537);
    send_free(48'hFFFF_FFFF_FF00 + 48'd65536);
    drain();
    configure(48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF);
    send_alloc(131071);
    send_alloc(131072);
    drain();
  endtask

  // fill every unit, hit the full report, then open a few scattered holes
  task automatic test_fill_pool();
    configure(48'h0, 48'd1);
    for (int i = 0; i < UNITS + 2; i++) begin
      quiet = (i >= UNITS / 4 && i < UNITS / 2);
      send_alloc($urandom_range(1));
    end
    quiet = 1'b0;
    for (int i = 0; i < 8; i++) send_free(48'(i * 131));
    drain();
  endtask

  task automatic test_random(int count);
    int k;
    int pick;
    logic [SIZE_W-1:0] us;
    us = usize_q;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_alloc(pick < 5 ? REQ_W'($urandom) : REQ_W'($urandom_range(us)));
      end else if (pick < 88 && granted.size() > 0) begin
        k = $urandom_range(granted.size() - 1);
        send_free(granted[k] + ADDR_W'(us > 1 ? $urandom_range(us - 1) : 0));
        granted.delete(k);
      end else if (pick < 94) begin
        send_free(ADDR_W'({$urandom, $urandom}));
      end else begin
        send_free(base_q + ADDR_W'($urandom_range(us * UNITS + 4)));
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    failed = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    base_q = '0;
    usize_q = SIZE_W'(64);
    for (int w = 0; w < MAP_WORDS; w++) occ_map[w] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_base_offset();
    test_zero_unit();
    test_wrap_and_big_units();
    test_fill_pool();
    configure(ADDR_W'({$urandom, $urandom}) >> 2, 48'd48);
    test_random(30);
    configure(48'hFFFF_FFFF_0000, 48'd3);
    test_random(25);
    configure(48'h0, 48'd65536);
    test_random(25);
    configure(ADDR_W'({$urandom, $urandom}), ADDR_W'({$urandom, $urandom}) | 48'h1);
    test_random(25);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
